// ===== design/urb_pkg.sv =====
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and constants for the uart register block: transaction kinds,
// register indexes, status and control bit positions, and the structs that
// connect the register file to the receive fifo.
// ----------------------------------------------------------------------------
`default_nettype none

package urb_pkg;

   localparam int unsigned RegWidth   = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned KindWidth  = 2;
   localparam int unsigned IndexWidth = 3;
   localparam int unsigned NumCtl     = 3;

   // control 0 bits
   localparam int unsigned BitTen = 3;
   localparam int unsigned BitRen = 2;

   // status bits
   localparam int unsigned BitTbe  = 7;
   localparam int unsigned BitTc   = 6;
   localparam int unsigned BitRbne = 5;

   localparam logic [RegWidth-1:0] MaskTxDone = RegWidth'((1 << BitTc) | (1 << BitTbe));
   localparam logic [RegWidth-1:0] MaskRbne   = RegWidth'(1 << BitRbne);

   // stream payload widths
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 48;

   typedef logic [RegWidth-1:0]   word_type;
   typedef logic [ByteWidth-1:0]  byte_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_PUSH  = 2'd2
   } kind_type;

   typedef enum logic [IndexWidth-1:0] {
      IDX_STAT = 3'd0,
      IDX_DATA = 3'd1,
      IDX_BAUD = 3'd2,
      IDX_CTL0 = 3'd3,
      IDX_CTL1 = 3'd4,
      IDX_CTL2 = 3'd5,
      IDX_GP   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [IndexWidth-1:0] reg_index;
      word_type              write_data;
      byte_type              rx_byte;
   } item_type;

   typedef struct packed {
      word_type read_data;
      logic     tx_valid;
      byte_type tx_byte;
      logic     rx_dropped;
   } result_type;

   typedef struct packed {
      logic     push;
      logic     pop;
      byte_type push_byte;
   } fifo_ctl_type;

   typedef struct packed {
      logic     empty;
      logic     single;
      logic     full;
      byte_type head_byte;
   } fifo_stat_type;

endpackage

`default_nettype wire

// ===== design/urb_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// urb_rx_fifo
// Receive fifo: byte memory with head pointer and fill count. The head entry
// is read into a register every cycle, with a bypass for a push into an
// empty fifo, so the oldest byte is always ready for a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_rx_fifo
   import urb_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fifo_ctl_type  ctl,
   output      fifo_stat_type stat
);

   localparam int unsigned AddrWidth  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned SumWidth   = CountWidth + 1;
   localparam logic [AddrWidth-1:0]  LastAddr   = AddrWidth'(FIFO_DEPTH - 1);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(FIFO_DEPTH);
   localparam logic [SumWidth-1:0]   DepthSum   = SumWidth'(FIFO_DEPTH);

   byte_type              mem [FIFO_DEPTH];
   byte_type              head_byte_ff;
   logic [AddrWidth-1:0]  head_ff, head_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SumWidth-1:0]   tail_sum;
   logic [AddrWidth-1:0]  tail_addr;

   always_comb begin
      tail_sum = SumWidth'(head_ff) + SumWidth'(count_ff);
      if (tail_sum >= DepthSum) begin
         tail_sum = tail_sum - DepthSum;
      end
      tail_addr = tail_sum[AddrWidth-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == LastAddr) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_addr] <= ctl.push_byte;
      end
   end

   // read port follows the next head, bypassing a write to the same entry
   always_ff @(posedge clock) begin
      if (ctl.push && (tail_addr == head_in)) begin
         head_byte_ff <= ctl.push_byte;
      end else begin
         head_byte_ff <= mem[head_in];
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.single    = (count_ff == CountWidth'(1));
   assign stat.full      = (count_ff == DepthCount);
   assign stat.head_byte = head_byte_ff;

endmodule

`default_nettype wire

// ===== design/urb_regfile.sv =====
// ----------------------------------------------------------------------------
// urb_regfile
// Status, data, baud, control and general-purpose registers with the
// decode of one transaction: register update, fifo push or pop, and result.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_regfile
   import urb_pkg::*;
#(
   parameter logic [31:0] STAT_RESET_VALUE  = 32'd192,
   parameter logic [31:0] OTHER_RESET_VALUE = 32'd0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire item_type      item,
   input  wire fifo_stat_type fifo_stat,
   output      fifo_ctl_type  fifo_ctl,
   output      result_type    result
);

   word_type status_ff, status_in;
   word_type data_ff, data_in;
   word_type baud_ff, baud_in;
   word_type ctl_ff [NumCtl];
   word_type ctl_in [NumCtl];
   word_type gp_ff, gp_in;

   logic     ten, ren;
   logic     push, pop, dropped, tx;
   word_type rdata;

   assign ten = ctl_ff[0][BitTen];
   assign ren = ctl_ff[0][BitRen];

   always_comb begin
      status_in = status_ff;
      data_in   = data_ff;
      baud_in   = baud_ff;
      ctl_in    = ctl_ff;
      gp_in     = gp_ff;
      push      = 1'b0;
      pop       = 1'b0;
      dropped   = 1'b0;
      tx        = 1'b0;
      rdata     = '0;
      case (kind_type'(item.kind))
         KIND_WRITE: begin
            case (reg_index_type'(item.reg_index))
               IDX_STAT: status_in = item.write_data;
               IDX_DATA: begin
                  data_in = item.write_data;
                  if (ten) begin
                     tx        = 1'b1;
                     status_in = status_ff | MaskTxDone;
                  end else if (ren) begin
                     status_in = status_ff | MaskRbne;
                  end
               end
               IDX_BAUD: baud_in   = item.write_data;
               IDX_CTL0: ctl_in[0] = item.write_data;
               IDX_CTL1: ctl_in[1] = item.write_data;
               IDX_CTL2: ctl_in[2] = item.write_data;
               IDX_GP:   gp_in     = item.write_data;
               default: ;
            endcase
         end
         KIND_READ: begin
            case (reg_index_type'(item.reg_index))
               IDX_STAT: rdata = status_ff;
               IDX_DATA: begin
                  if (ren) begin
                     if (!fifo_stat.empty) begin
                        pop     = 1'b1;
                        data_in = {{(RegWidth-ByteWidth){1'b0}}, fifo_stat.head_byte};
                     end
                     if (fifo_stat.empty || fifo_stat.single) begin
                        status_in = status_ff & ~MaskRbne;
                     end
                  end
                  rdata = data_in;
               end
               IDX_BAUD: rdata = baud_ff;
               IDX_CTL0: begin
                  rdata = ctl_ff[0];
                  if (ren && !fifo_stat.empty) begin
                     pop     = 1'b1;
                     data_in = {{(RegWidth-ByteWidth){1'b0}}, fifo_stat.head_byte};
                     if (ten) begin
                        tx        = 1'b1;
                        status_in = status_ff | MaskTxDone;
                     end else begin
                        status_in = status_ff | MaskRbne;
                     end
                  end
               end
               IDX_CTL1: rdata = ctl_ff[1];
               IDX_CTL2: rdata = ctl_ff[2];
               IDX_GP:   rdata = gp_ff;
               default:  rdata = '0;
            endcase
         end
         KIND_PUSH: begin
            if (fifo_stat.full) begin
               dropped = 1'b1;
            end else begin
               push = 1'b1;
            end
            status_in = status_ff | MaskRbne;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STAT_RESET_VALUE;
         data_ff   <= OTHER_RESET_VALUE;
         baud_ff   <= OTHER_RESET_VALUE;
         for (int i = 0; i < NumCtl; i++) begin
            ctl_ff[i] <= OTHER_RESET_VALUE;
         end
         gp_ff     <= OTHER_RESET_VALUE;
      end else if (advance) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         baud_ff   <= baud_in;
         ctl_ff    <= ctl_in;
         gp_ff     <= gp_in;
      end
   end

   assign fifo_ctl.push      = advance && push;
   assign fifo_ctl.pop       = advance && pop;
   assign fifo_ctl.push_byte = item.rx_byte;

   assign result.read_data  = rdata;
   assign result.tx_valid   = tx;
   assign result.tx_byte    = tx ? data_in[ByteWidth-1:0] : '0;
   assign result.rx_dropped = dropped;

endmodule

`default_nettype wire

// ===== design/uart_register_block.sv =====
// ----------------------------------------------------------------------------
// uart_register_block
// Register view of a uart with a receive fifo. Bus writes, bus reads and host
// byte pushes arrive as request transactions; each gives one response.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tuser kind, req_tdata fields
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata result fields
//
// A request is taken into the input register, is decoded against the
// registers and fifo, and its response is registered; one transaction per
// cycle is sustained while the response side does not stall.
// Reset is synchronous; the fifo memory is not cleared, only its count and
// head.
// A stalled response holds the input register, which then stalls requests.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_block
   import urb_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH        = 16,
   parameter logic [31:0] STAT_RESET_VALUE  = 32'd192,
   parameter logic [31:0] OTHER_RESET_VALUE = 32'd0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   // [2:0] reg_index, [34:3] write_data, [42:35] rx_byte, [47:43] zero
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // [1:0] kind
   input  wire logic [KindWidth-1:0]    req_tuser,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [31:0] read_data, [32] tx_valid, [40:33] tx_byte, [41] rx_dropped, [47:42] zero
   output      logic [RspDataWidth-1:0] rsp_tdata
);

   localparam int unsigned RspUsed = RegWidth + 1 + ByteWidth + 1;

   logic          in_valid_ff;
   item_type      item_ff, item_in;
   logic          rsp_valid_ff;
   result_type    result_ff, result;
   logic          advance;
   logic          req_fire;
   fifo_ctl_type  fifo_ctl;
   fifo_stat_type fifo_stat;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign item_in.kind       = req_tuser;
   assign item_in.reg_index  = req_tdata[2:0];
   assign item_in.write_data = req_tdata[34:3];
   assign item_in.rx_byte    = req_tdata[42:35];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   urb_regfile #(
      .STAT_RESET_VALUE  (STAT_RESET_VALUE),
      .OTHER_RESET_VALUE (OTHER_RESET_VALUE)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .fifo_stat (fifo_stat),
      .fifo_ctl  (fifo_ctl),
      .result    (result)
   );

   urb_rx_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_rx_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .stat  (fifo_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-RspUsed){1'b0}}, result_ff.rx_dropped,
                        result_ff.tx_byte, result_ff.tx_valid, result_ff.read_data};

endmodule

`default_nettype wire

// ===== design/urb_checker.sv =====
// ----------------------------------------------------------------------------
// urb_checker
// Port-level checks for the uart register block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_checker
   import urb_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tvalid,
   input wire logic                    req_tready,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [RspDataWidth-1:0] rsp_tdata
);

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // no transmitted byte without tx_valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[40:33] == '0)
      else $error("tx byte without tx valid");

   // a push never transmits, a transmit never drops
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[41]))
      else $error("tx and drop in one response");

   // a free response side never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !req_tready |=> rsp_tvalid)
      else $error("request stall without response stall");

endmodule

bind uart_register_block urb_checker u_urb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
